### rtl/assert_macros.svh
// Assertion macros shared by the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Concurrent check on a clock, off while reset is low.
`define ASFL_ASSERT(lbl, clk, rstn, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);

// Implication with the consequent in the same cycle.
`define ASFL_ASSERT_IMP(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) else $error(msg);

// Implication with the consequent in the next cycle.
`define ASFL_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) else $error(msg);

`endif

### rtl/asfl_pkg.sv
// Shared constants and types of the escape stripper and line filter.
package asfl_pkg;

    localparam int MAX_LINE      = 8192;
    localparam int NUM_PAT       = 4;
    localparam int PB            = 8;                      // pattern bytes
    localparam int WIN_W         = 8 * PB;
    localparam int LEN_W         = $clog2(PB + 1);
    localparam int SH_W          = $clog2(WIN_W + 1);
    localparam int ACT_W         = $clog2(NUM_PAT + 1);
    localparam int RAW_W         = $clog2(MAX_LINE + 1);
    localparam int CFG_W         = 64;
    localparam int IDX_W         = 3;
    localparam int CNT_REG_W     = 3;
    localparam int LENS_REG_W    = 16;
    localparam int NIB_W         = 4;
    localparam int FIFO_DEPTH    = 2;

    localparam logic [7:0] CH_ESC     = 8'h1b;
    localparam logic [7:0] CH_BRACKET = 8'h5b;
    localparam logic [7:0] CH_M       = 8'h6d;
    localparam logic [7:0] CH_NL      = 8'h0a;

    typedef enum logic [IDX_W-1:0] {
        REG_COUNT   = 3'd0,
        REG_PAT_A   = 3'd1,
        REG_PAT_B   = 3'd2,
        REG_PAT_C   = 3'd3,
        REG_PAT_D   = 3'd4,
        REG_LENGTHS = 3'd5
    } t_reg_idx;

    typedef logic [NUM_PAT-1:0][WIN_W-1:0] t_pats;
    typedef logic [NUM_PAT-1:0][LEN_W-1:0] t_lens;

    typedef struct packed {
        logic       out_kind;
        logic [7:0] out_byte;
        logic       line_keep;
        logic       line_too_long;
        logic       line_empty;
        logic       last_of_run;
    } t_result;

    // one or two results caused by one input word
    typedef struct packed {
        logic    two;
        t_result r0;
        t_result r1;
    } t_entry;

    typedef struct packed {
        logic   valid;
        t_entry entry;
    } t_push;

endpackage

### rtl/asfl_if.sv
// Handshake interfaces: input bytes, results and configuration writes.
interface asfl_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] in_byte;
    modport source (output valid, output in_byte, input ready);
    modport sink   (input valid, input in_byte, output ready);
endinterface

interface asfl_out_if;
    logic       valid;
    logic       ready;
    logic       out_kind;
    logic [7:0] out_byte;
    logic       line_keep;
    logic       line_too_long;
    logic       line_empty;
    logic       last_of_run;
    modport source (output valid, output out_kind, output out_byte, output line_keep,
                    output line_too_long, output line_empty, output last_of_run,
                    input ready);
    modport sink   (input valid, input out_kind, input out_byte, input line_keep,
                    input line_too_long, input line_empty, input last_of_run,
                    output ready);
endinterface

interface asfl_cfg_if;
    logic                        valid;
    logic                        ready;
    logic [asfl_pkg::IDX_W-1:0]  index;
    logic [asfl_pkg::CFG_W-1:0]  data;
    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

### rtl/asfl_match.sv
// Window shift and parallel pattern compare for one kept byte.
module asfl_match (
    input  logic [asfl_pkg::WIN_W-1:0]  i_window,
    input  logic [asfl_pkg::LEN_W-1:0]  i_fill,
    input  logic [7:0]                  i_byte,
    input  asfl_pkg::t_pats             i_pats,
    input  asfl_pkg::t_lens             i_lens,
    input  logic [asfl_pkg::ACT_W-1:0]  i_active,
    output logic [asfl_pkg::WIN_W-1:0]  o_window,
    output logic [asfl_pkg::LEN_W-1:0]  o_fill,
    output logic [asfl_pkg::NUM_PAT-1:0] o_hits
);
    import asfl_pkg::*;

    logic [SH_W-1:0]  amt  [NUM_PAT];
    logic [WIN_W-1:0] mask [NUM_PAT];

    // newest byte enters the top octet
    assign o_window = {i_byte, i_window[WIN_W-1:8]};
    assign o_fill   = (i_fill < LEN_W'(PB)) ? i_fill + LEN_W'(1) : i_fill;

    always_comb begin
        for (int i = 0; i < NUM_PAT; i++) begin
            amt[i]  = SH_W'(8 * (PB - int'(i_lens[i])));
            mask[i] = {WIN_W{1'b1}} >> amt[i];
            o_hits[i] = (ACT_W'(i) < i_active) && (i_lens[i] != '0) &&
                        (o_fill >= i_lens[i]) &&
                        (((o_window >> amt[i]) & mask[i]) == (i_pats[i] & mask[i]));
        end
    end

endmodule

### rtl/asfl_fifo.sv
// Result queue: entries of one or two results, drained one word a cycle while the reader is ready.
module asfl_fifo (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  asfl_pkg::t_push   i_push,
    input  logic              i_pop_ready,
    output logic              o_room,
    output logic              o_head_valid,
    output asfl_pkg::t_result o_head
);
    import asfl_pkg::*;

    localparam int PTR_W = (FIFO_DEPTH > 1) ? $clog2(FIFO_DEPTH) : 1;
    localparam int CNT_W = $clog2(FIFO_DEPTH + 1);

    t_entry           r_mem [FIFO_DEPTH];
    logic [PTR_W-1:0] r_wr, r_rd;
    logic [CNT_W-1:0] r_count;
    logic             r_sub;          // second result of the head entry is up
    logic             pop_done, push_do;

    assign o_head_valid = (r_count != '0);
    assign o_head       = r_sub ? r_mem[r_rd].r1 : r_mem[r_rd].r0;
    assign pop_done     = o_head_valid && i_pop_ready && (r_sub || !r_mem[r_rd].two);
    assign o_room       = (r_count != CNT_W'(FIFO_DEPTH)) || pop_done;
    assign push_do      = i_push.valid && o_room;

    always_ff @(posedge i_clk) begin
        if (push_do) begin
            r_mem[r_wr] <= i_push.entry;
        end
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
            r_sub   <= 1'b0;
        end else begin
            if (push_do) begin
                r_wr <= (r_wr == PTR_W'(FIFO_DEPTH - 1)) ? '0 : r_wr + PTR_W'(1);
            end
            if (o_head_valid && i_pop_ready) begin
                r_sub <= !pop_done;
            end
            if (pop_done) begin
                r_rd <= (r_rd == PTR_W'(FIFO_DEPTH - 1)) ? '0 : r_rd + PTR_W'(1);
            end
            r_count <= r_count + CNT_W'(push_do) - CNT_W'(pop_done);
        end
    end

endmodule

### rtl/ansi_strip_line_substring_filter.sv
// Top level: ANSI escape stripper with per-line substring verdicts.
// Order: an accepted byte is registered, and its results enter the output queue once the
// queue has room; the output shows the head of the queue.
// Throughput: one byte per cycle while the output queue has room; a byte that yields two
// results holds the output for both words, set by the single-word result port.
// Reset: synchronous active low, clears line state, queue and all config registers.
`include "assert_macros.svh"

module ansi_strip_line_substring_filter (
    input  logic        i_clk,
    input  logic        i_rst_n,
    asfl_in_if.sink     i_in,
    asfl_cfg_if.sink    i_cfg,
    asfl_out_if.source  o_out
);
    import asfl_pkg::*;

    // ---------------- configuration registers ----------------
    logic [CNT_REG_W-1:0]  r_pat_count;
    t_pats                 r_pats;
    logic [LENS_REG_W-1:0] r_pat_lens;

    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pat_count <= '0;
            r_pats      <= '0;
            r_pat_lens  <= '0;
        end else if (i_cfg.valid) begin
            unique case (i_cfg.index)
                REG_COUNT:   r_pat_count <= i_cfg.data[CNT_REG_W-1:0];
                REG_PAT_A:   r_pats[0]   <= i_cfg.data[WIN_W-1:0];
                REG_PAT_B:   r_pats[1]   <= i_cfg.data[WIN_W-1:0];
                REG_PAT_C:   r_pats[2]   <= i_cfg.data[WIN_W-1:0];
                REG_PAT_D:   r_pats[3]   <= i_cfg.data[WIN_W-1:0];
                REG_LENGTHS: r_pat_lens  <= i_cfg.data[LENS_REG_W-1:0];
                default: ;   // unmapped index, write dropped
            endcase
        end
    end

    // saturated active count and lengths
    logic [ACT_W-1:0] active;
    t_lens            lens;
    logic [NIB_W-1:0] nib [NUM_PAT];

    always_comb begin
        active = (r_pat_count > CNT_REG_W'(NUM_PAT)) ? ACT_W'(NUM_PAT)
                                                     : ACT_W'(r_pat_count);
        for (int i = 0; i < NUM_PAT; i++) begin
            nib[i]  = r_pat_lens[NIB_W*i +: NIB_W];
            lens[i] = (nib[i] > NIB_W'(PB)) ? LEN_W'(PB) : LEN_W'(nib[i]);
        end
    end

    // ---------------- input register ----------------
    logic       r_in_valid;
    logic [7:0] r_in_byte;
    logic       room, fire;

    assign fire       = r_in_valid && room;
    assign i_in.ready = !r_in_valid || fire;

    always_ff @(posedge i_clk) begin
        if (i_in.valid && i_in.ready) begin
            r_in_byte <= i_in.in_byte;
        end
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_in.ready) begin
            r_in_valid <= i_in.valid;
        end
    end

    // ---------------- line state ----------------
    logic               r_esc_pending, r_in_escape, r_line_nonempty;
    logic [WIN_W-1:0]   r_window;
    logic [LEN_W-1:0]   r_fill;
    logic [RAW_W-1:0]   r_raw_len;
    logic [NUM_PAT-1:0] r_hits;

    logic               is_nl;
    logic               keep_esc;    // held ESC comes out first
    logic               keep_cur;    // current byte comes out after it
    logic [WIN_W-1:0]   win_a, win_b, win_mid;
    logic [LEN_W-1:0]   fill_a, fill_b, fill_mid;
    logic [NUM_PAT-1:0] hits_a, hits_b, hits_mid, hits_end;
    logic               matched, too_long, nonempty_mid;

    assign is_nl    = (r_in_byte == CH_NL);
    assign keep_esc = r_esc_pending && !r_in_escape && (is_nl || r_in_byte != CH_BRACKET);
    assign keep_cur = !is_nl && !r_in_escape && (r_in_byte != CH_ESC) &&
                      !(r_esc_pending && r_in_byte == CH_BRACKET);

    // held ESC goes through the window first
    asfl_match u_match_esc (
        .i_window (r_window),
        .i_fill   (r_fill),
        .i_byte   (CH_ESC),
        .i_pats   (r_pats),
        .i_lens   (lens),
        .i_active (active),
        .o_window (win_a),
        .o_fill   (fill_a),
        .o_hits   (hits_a)
    );

    assign win_mid  = keep_esc ? win_a  : r_window;
    assign fill_mid = keep_esc ? fill_a : r_fill;
    assign hits_mid = r_hits | (keep_esc ? hits_a : '0);

    asfl_match u_match_cur (
        .i_window (win_mid),
        .i_fill   (fill_mid),
        .i_byte   (r_in_byte),
        .i_pats   (r_pats),
        .i_lens   (lens),
        .i_active (active),
        .o_window (win_b),
        .o_fill   (fill_b),
        .o_hits   (hits_b)
    );

    assign hits_end     = hits_mid | (keep_cur ? hits_b : '0);
    assign nonempty_mid = r_line_nonempty || keep_esc;
    assign too_long     = (r_raw_len >= RAW_W'(MAX_LINE));

    // verdict uses hits after the held ESC; an active zero-length pattern always matches
    always_comb begin
        matched = (active == '0);
        for (int i = 0; i < NUM_PAT; i++) begin
            if ((ACT_W'(i) < active) && (lens[i] == '0 || hits_mid[i])) begin
                matched = 1'b1;
            end
        end
    end

    // ---------------- result assembly ----------------
    t_result res_esc, res_cur, res_verdict;
    t_push   push;

    always_comb begin
        res_esc     = '{out_kind: 1'b0, out_byte: CH_ESC, line_keep: 1'b0,
                        line_too_long: 1'b0, line_empty: 1'b0, last_of_run: 1'b0};
        res_cur     = '{out_kind: 1'b0, out_byte: r_in_byte, line_keep: 1'b0,
                        line_too_long: 1'b0, line_empty: 1'b0, last_of_run: 1'b1};
        res_verdict = '{out_kind: 1'b1, out_byte: 8'h00,
                        line_keep: nonempty_mid && !too_long && matched,
                        line_too_long: too_long, line_empty: !nonempty_mid,
                        last_of_run: 1'b1};

        push.entry.two = keep_esc && (is_nl || keep_cur);
        push.entry.r0  = keep_esc ? res_esc : (is_nl ? res_verdict : res_cur);
        push.entry.r1  = is_nl ? res_verdict : res_cur;
        // a lone result is the last of its run
        if (!push.entry.two) begin
            push.entry.r0.last_of_run = 1'b1;
        end
        push.valid = fire && (is_nl || keep_esc || keep_cur);
    end

    // ---------------- state update ----------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || (fire && is_nl)) begin
            r_esc_pending   <= 1'b0;
            r_in_escape     <= 1'b0;
            r_line_nonempty <= 1'b0;
            r_window        <= '0;
            r_fill          <= '0;
            r_raw_len       <= '0;
            r_hits          <= '0;
        end else if (fire) begin
            if (r_raw_len < RAW_W'(MAX_LINE)) begin
                r_raw_len <= r_raw_len + RAW_W'(1);
            end
            r_in_escape     <= r_in_escape ? (r_in_byte != CH_M)
                                           : (r_esc_pending && r_in_byte == CH_BRACKET);
            r_esc_pending   <= !r_in_escape && (r_in_byte == CH_ESC);
            r_line_nonempty <= nonempty_mid || keep_cur;
            r_window        <= keep_cur ? win_b  : win_mid;
            r_fill          <= keep_cur ? fill_b : fill_mid;
            r_hits          <= hits_end;
        end
    end

    // ---------------- output queue ----------------
    t_result head;

    asfl_fifo u_fifo (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push       (push),
        .i_pop_ready  (o_out.ready),
        .o_room       (room),
        .o_head_valid (o_out.valid),
        .o_head       (head)
    );

    assign o_out.out_kind      = head.out_kind;
    assign o_out.out_byte      = head.out_byte;
    assign o_out.line_keep     = head.line_keep;
    assign o_out.line_too_long = head.line_too_long;
    assign o_out.line_empty    = head.line_empty;
    assign o_out.last_of_run   = head.last_of_run;

    // ---------------- checks ----------------
    logic esc_both, verdict_out, text_out, keep_clean, text_flags, line_dirty, nl_fire;

    assign esc_both    = r_esc_pending && r_in_escape;
    assign verdict_out = o_out.valid && o_out.out_kind;
    assign text_out    = o_out.valid && !o_out.out_kind;
    assign keep_clean  = !(o_out.line_keep && (o_out.line_too_long || o_out.line_empty));
    assign text_flags  = o_out.line_keep || o_out.line_too_long || o_out.line_empty;
    assign line_dirty  = (r_raw_len != '0) || r_line_nonempty || (r_hits != '0);
    assign nl_fire     = fire && is_nl;

    `ASFL_ASSERT(a_esc_exclusive, i_clk, i_rst_n, !esc_both, "held ESC inside escape")
    `ASFL_ASSERT_IMP(a_keep_sane, i_clk, i_rst_n, verdict_out, keep_clean, "kept line dropped")
    `ASFL_ASSERT_IMP(a_text_clean, i_clk, i_rst_n, text_out, !text_flags, "flags on text word")
    `ASFL_ASSERT_NEXT(a_line_clear, i_clk, i_rst_n, nl_fire, !line_dirty, "line not cleared")

endmodule
